// ===== hw/rtl/stcrg_pkg.sv =====
// Shared types, widths and constants for the step-then-chirp reference generator.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
package stcrg_pkg;

  localparam int PHASE_BITS = 10;

  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 24;
  localparam int FREQ_W   = 24;
  localparam int SEG_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_W    = 32;
  localparam int PROD_W   = TIME_W + TIME_W + FREQ_W;
  // The quotient f*s*s/d stays below 2^56, so the top TIME_W dividend bits
  // are already smaller than the divisor.
  localparam int DIV_STEPS = PROD_W - TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // Only the quotient bits below one turn (2^37) matter.
  localparam int QUO_W    = 37;

  localparam logic [28:0] SINE_A = 29'd421657428;
  localparam logic [27:0] SINE_B = 28'd172226216;
  localparam logic [24:0] SINE_C = 25'd19004244;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_ONE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TWO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_THREE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FOUR  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LEN   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LVL  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LEN  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_FREQ = 8'd7;

  localparam logic [SEG_W-1:0] SEG_STEP_ONE   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_STEP_TWO   = 3'd1;
  localparam logic [SEG_W-1:0] SEG_STEP_THREE = 3'd2;
  localparam logic [SEG_W-1:0] SEG_STEP_FOUR  = 3'd3;
  localparam logic [SEG_W-1:0] SEG_SWEEP      = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLASSIFY, ST_SWEEP, ST_SQ, ST_SQW, ST_FLO, ST_FHI, ST_FSUM,
    ST_DIV, ST_X2, ST_X2W, ST_C, ST_CW, ST_T2, ST_T2W, ST_TX, ST_TXW,
    ST_AMP, ST_AMPW, ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/stcrg_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on stcrg_pkg for operand widths.
module stcrg_mul (
  input  logic                             clk,
  input  logic [stcrg_pkg::MUL_W-1:0]      a,
  input  logic [stcrg_pkg::MUL_W-1:0]      b,
  output logic [2*stcrg_pkg::MUL_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/stcrg_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, keeping the low quotient bits.
// Depends on stcrg_pkg for widths and step count.
module stcrg_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [stcrg_pkg::PROD_W-1:0]      dividend,
  input  logic [stcrg_pkg::TIME_W-1:0]      divisor,
  output logic                              done,
  output logic [stcrg_pkg::QUO_W-1:0]       quotient
);

  logic [stcrg_pkg::TIME_W-1:0]    rem;
  logic [stcrg_pkg::TIME_W-1:0]    rem_next;
  logic [stcrg_pkg::DIV_STEPS-1:0] low;
  logic [stcrg_pkg::TIME_W-1:0]    dv;
  logic [stcrg_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic [stcrg_pkg::TIME_W:0]      trial;
  logic [stcrg_pkg::TIME_W:0]      diff;
  logic                            ge;

  always_comb begin
    trial    = {rem, low[stcrg_pkg::DIV_STEPS-1]};
    diff     = trial - {1'b0, dv};
    ge       = trial >= {1'b0, dv};
    rem_next = ge ? diff[stcrg_pkg::TIME_W-1:0] : trial[stcrg_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        rem  <= dividend[stcrg_pkg::PROD_W-1 -: stcrg_pkg::TIME_W];
        low  <= dividend[stcrg_pkg::DIV_STEPS-1:0];
        dv   <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        rem      <= rem_next;
        low      <= low << 1;
        quotient <= {quotient[stcrg_pkg::QUO_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == stcrg_pkg::DIV_CNT_W'(stcrg_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/step_then_chirp_reference_generator.sv =====
// Top level of the stepped-profile and linear-chirp reference generator.
// Depends on stcrg_pkg, stcrg_mul and stcrg_div.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    current_time
// out       out        out_valid / out_ready  reference_value, segment
//
// A step item is classified and then loaded into the output register from ST_FINISH.
// A sweep item also passes the square, the frequency product, the 56-step divider
// forming the phase and the sine polynomial; the divider dominates, and each product
// of the shared multiplier is taken in the state after its issue. A zero sweep length goes from ST_SWEEP to ST_FINISH.
// Synchronous reset restores the register reset values and clears the sweep latch.
// One item is in work at a time; in_ready is high only while the sequencer idles.
// A result waiting in the output register does not block acceptance of the next
// transaction; the sequencer waits only when it must load a still-occupied register.
module step_then_chirp_reference_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [stcrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stcrg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [stcrg_pkg::TIME_W-1:0]          current_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [stcrg_pkg::LEVEL_W-1:0]  reference_value,
  output logic [stcrg_pkg::SEG_W-1:0]           segment
);

  // Configuration registers.
  logic [stcrg_pkg::LEVEL_W-1:0] step_one_level;
  logic [stcrg_pkg::LEVEL_W-1:0] step_two_level;
  logic [stcrg_pkg::LEVEL_W-1:0] step_three_level;
  logic [stcrg_pkg::LEVEL_W-1:0] step_four_level;
  logic [stcrg_pkg::TIME_W-1:0]  step_length;
  logic [stcrg_pkg::LEVEL_W-1:0] sweep_level;
  logic [stcrg_pkg::TIME_W-1:0]  sweep_length;
  logic [stcrg_pkg::FREQ_W-1:0]  sweep_top_freq;

  // Sweep start latch.
  logic [stcrg_pkg::TIME_W-1:0]  sweep_start_time;
  logic                          sweep_started;

  stcrg_pkg::state_t state;
  stcrg_pkg::state_t state_next;

  // Working registers of the sequencer.
  logic [stcrg_pkg::TIME_W-1:0]  time_q;
  logic [stcrg_pkg::SEG_W-1:0]   seg_q;
  logic [stcrg_pkg::LEVEL_W-1:0] res_q;
  logic [stcrg_pkg::TIME_W-1:0]  s_q;
  logic [2*stcrg_pkg::TIME_W-1:0] sq_q;
  logic [55:0]                   lo_q;
  logic [14:0]                   x_q;
  logic [28:0]                   x2_q;
  logic [28:0]                   t_q;
  logic [29:0]                   y_q;
  logic                          neg_q;

  // Shared multiplier and divider connections.
  logic [stcrg_pkg::MUL_W-1:0]   mul_a;
  logic [stcrg_pkg::MUL_W-1:0]   mul_b;
  logic [2*stcrg_pkg::MUL_W-1:0] mul_p;
  logic                          div_start;
  logic                          div_done;
  logic [stcrg_pkg::QUO_W-1:0]   div_quo;
  logic [stcrg_pkg::PROD_W-1:0]  prod;

  // Step limits at 34 bits so that 2L, 3L and 4L never wrap.
  logic [33:0] lim1, lim2, lim3, lim4, t34;
  logic [stcrg_pkg::TIME_W-1:0]  tdiff;
  logic [stcrg_pkg::PHASE_BITS-1:0] idx;
  logic [15:0]                   ph16;
  logic [14:0]                   x_new;
  logic [stcrg_pkg::LEVEL_W-1:0] mag;
  logic [63:0]                   rsum;
  logic [35:0]                   rmag;
  logic                          res_neg;
  logic                          out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    t34   = {2'b00, time_q};
    lim1  = {2'b00, step_length};
    lim2  = {1'b0, step_length, 1'b0};
    lim3  = lim1 + lim2;
    lim4  = {step_length, 2'b00};
    // A time before the latched start counts as the start itself.
    tdiff = (time_q >= sweep_start_time) ? time_q - sweep_start_time : '0;
    prod  = {mul_p[55:0], 32'd0} + {32'd0, lo_q};
    idx   = div_quo[stcrg_pkg::QUO_W-1 -: stcrg_pkg::PHASE_BITS];
    ph16  = 16'(idx) << (16 - stcrg_pkg::PHASE_BITS);
    // Fold into the first quarter wave; odd quarters run backwards.
    x_new = ph16[14] ? 15'(15'd16384 - {1'b0, ph16[13:0]}) : {1'b0, ph16[13:0]};
    mag   = sweep_level[stcrg_pkg::LEVEL_W-1] ? 24'(-sweep_level) : sweep_level;
    rsum  = mul_p + 64'd134217728;
    rmag  = rsum[63:28];
    res_neg = sweep_level[stcrg_pkg::LEVEL_W-1] ^ neg_q;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stcrg_pkg::ST_IDLE:     if (in_valid) state_next = stcrg_pkg::ST_CLASSIFY;
      stcrg_pkg::ST_CLASSIFY: state_next = (t34 > lim4) ? stcrg_pkg::ST_SWEEP
                                                        : stcrg_pkg::ST_FINISH;
      stcrg_pkg::ST_SWEEP:    state_next = (sweep_length == '0) ? stcrg_pkg::ST_FINISH
                                                                : stcrg_pkg::ST_SQ;
      stcrg_pkg::ST_SQ:       state_next = stcrg_pkg::ST_SQW;
      stcrg_pkg::ST_SQW:      state_next = stcrg_pkg::ST_FLO;
      stcrg_pkg::ST_FLO:      state_next = stcrg_pkg::ST_FHI;
      stcrg_pkg::ST_FHI:      state_next = stcrg_pkg::ST_FSUM;
      stcrg_pkg::ST_FSUM:     state_next = stcrg_pkg::ST_DIV;
      stcrg_pkg::ST_DIV:      if (div_done) state_next = stcrg_pkg::ST_X2;
      stcrg_pkg::ST_X2:       state_next = stcrg_pkg::ST_X2W;
      stcrg_pkg::ST_X2W:      state_next = stcrg_pkg::ST_C;
      stcrg_pkg::ST_C:        state_next = stcrg_pkg::ST_CW;
      stcrg_pkg::ST_CW:       state_next = stcrg_pkg::ST_T2;
      stcrg_pkg::ST_T2:       state_next = stcrg_pkg::ST_T2W;
      stcrg_pkg::ST_T2W:      state_next = stcrg_pkg::ST_TX;
      stcrg_pkg::ST_TX:       state_next = stcrg_pkg::ST_TXW;
      stcrg_pkg::ST_TXW:      state_next = stcrg_pkg::ST_AMP;
      stcrg_pkg::ST_AMP:      state_next = stcrg_pkg::ST_AMPW;
      stcrg_pkg::ST_AMPW:     state_next = stcrg_pkg::ST_FINISH;
      stcrg_pkg::ST_FINISH:   if (out_free) state_next = stcrg_pkg::ST_IDLE;
      default:                state_next = stcrg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and divider start.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      stcrg_pkg::ST_IDLE: in_ready = 1'b1;
      stcrg_pkg::ST_SQ: begin
        mul_a = s_q;
        mul_b = s_q;
      end
      stcrg_pkg::ST_FLO: begin
        mul_a = sq_q[31:0];
        mul_b = {8'd0, sweep_top_freq};
      end
      stcrg_pkg::ST_FHI: begin
        mul_a = sq_q[63:32];
        mul_b = {8'd0, sweep_top_freq};
      end
      stcrg_pkg::ST_FSUM: div_start = 1'b1;
      stcrg_pkg::ST_X2: begin
        mul_a = {17'd0, x_q};
        mul_b = {17'd0, x_q};
      end
      stcrg_pkg::ST_C: begin
        mul_a = {7'd0, stcrg_pkg::SINE_C};
        mul_b = {3'd0, x2_q};
      end
      stcrg_pkg::ST_T2: begin
        mul_a = {3'd0, t_q};
        mul_b = {3'd0, x2_q};
      end
      stcrg_pkg::ST_TX: begin
        mul_a = {3'd0, t_q};
        mul_b = {17'd0, x_q};
      end
      stcrg_pkg::ST_AMP: begin
        mul_a = {8'd0, mag};
        mul_b = {2'd0, y_q};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= stcrg_pkg::ST_IDLE;
      out_valid        <= 1'b0;
      sweep_started    <= 1'b0;
      sweep_start_time <= '0;
      step_one_level   <= '0;
      step_two_level   <= '0;
      step_three_level <= '0;
      step_four_level  <= '0;
      step_length      <= 32'd1048576;
      sweep_level      <= '0;
      sweep_length     <= 32'd1048576;
      sweep_top_freq   <= 24'd65536;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stcrg_pkg::REG_STEP_ONE:   step_one_level   <= cfg_data[23:0];
          stcrg_pkg::REG_STEP_TWO:   step_two_level   <= cfg_data[23:0];
          stcrg_pkg::REG_STEP_THREE: step_three_level <= cfg_data[23:0];
          stcrg_pkg::REG_STEP_FOUR:  step_four_level  <= cfg_data[23:0];
          stcrg_pkg::REG_STEP_LEN:   step_length      <= cfg_data;
          stcrg_pkg::REG_SWEEP_LVL:  sweep_level      <= cfg_data[23:0];
          stcrg_pkg::REG_SWEEP_LEN:  sweep_length     <= cfg_data;
          stcrg_pkg::REG_SWEEP_FREQ: sweep_top_freq   <= cfg_data[23:0];
          default: ;
        endcase
      end

      // In the finishing state the load below takes over the output register.
      if (out_valid && out_ready && state != stcrg_pkg::ST_FINISH) out_valid <= 1'b0;

      unique case (state)
        stcrg_pkg::ST_IDLE: if (in_valid) time_q <= current_time;
        stcrg_pkg::ST_CLASSIFY: begin
          priority if (t34 <= lim1) begin
            seg_q <= stcrg_pkg::SEG_STEP_ONE;
            res_q <= step_one_level;
          end else if (t34 <= lim2) begin
            seg_q <= stcrg_pkg::SEG_STEP_TWO;
            res_q <= step_two_level;
          end else if (t34 <= lim3) begin
            seg_q <= stcrg_pkg::SEG_STEP_THREE;
            res_q <= step_three_level;
          end else if (t34 <= lim4) begin
            seg_q <= stcrg_pkg::SEG_STEP_FOUR;
            res_q <= step_four_level;
          end else begin
            seg_q <= stcrg_pkg::SEG_SWEEP;
            // The first sweep item latches the start, once per reset.
            if (!sweep_started) begin
              sweep_started    <= 1'b1;
              sweep_start_time <= time_q;
            end
          end
        end
        stcrg_pkg::ST_SWEEP: begin
          res_q <= '0;
          s_q   <= (tdiff > sweep_length) ? sweep_length : tdiff;
        end
        stcrg_pkg::ST_SQW: sq_q <= mul_p;
        stcrg_pkg::ST_FHI: lo_q <= mul_p[55:0];
        stcrg_pkg::ST_DIV: begin
          if (div_done) begin
            x_q   <= x_new;
            neg_q <= ph16[15];
          end
        end
        stcrg_pkg::ST_X2W: x2_q <= mul_p[28:0];
        stcrg_pkg::ST_CW:  t_q  <= 29'(stcrg_pkg::SINE_B) - 29'(mul_p[53:28]);
        stcrg_pkg::ST_T2W: t_q  <= stcrg_pkg::SINE_A - mul_p[56:28];
        stcrg_pkg::ST_TXW: y_q  <= mul_p[43:14];
        stcrg_pkg::ST_AMPW: begin
          // Round half away from zero on the magnitude, then apply the sign.
          if (res_neg) begin
            res_q <= 24'(-rmag);
          end else if (rmag > 36'd8388607) begin
            res_q <= 24'h7FFFFF;
          end else begin
            res_q <= rmag[23:0];
          end
        end
        stcrg_pkg::ST_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            reference_value <= res_q;
            segment         <= seg_q;
          end
        end
        default: ;
      endcase
    end
  end

  stcrg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  stcrg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (sweep_length),
    .done     (div_done),
    .quotient (div_quo)
  );

  a_accept_classify: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == stcrg_pkg::ST_CLASSIFY)
    else $error("accepted transaction did not enter classification");

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    sweep_started |=> sweep_started)
    else $error("sweep start latch cleared without reset");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == stcrg_pkg::ST_DIV)
    else $error("divider finished outside the division state");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == stcrg_pkg::ST_FINISH && out_free |=> out_valid)
    else $error("finished result was not loaded into the output register");

endmodule
